// ===== rtl/core/load_regulated_threshold_tuner_assert.svh =====
// assertion macros used by the tuner control fsm
`ifndef LOAD_REGULATED_THRESHOLD_TUNER_ASSERT_SVH
`define LOAD_REGULATED_THRESHOLD_TUNER_ASSERT_SVH

// same-cycle implication
`define LRTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrtt: implication check failed");

// next-cycle implication
`define LRTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrtt: next-cycle check failed");

`endif

// ===== rtl/core/lrtt_pkg.sv =====
`default_nettype none

package lrtt_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned TotalW = 48;
  localparam int unsigned QW     = 17;
  localparam int unsigned SweepW = 24;
  localparam int unsigned TickW  = 16;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // shared serial divider
  localparam int unsigned DivW  = 48;
  localparam int unsigned DvsW  = 24;
  localparam int unsigned DivCntW = 6;
  localparam logic [DivCntW-1:0] LoadSteps  = 6'd32;
  localparam logic [DivCntW-1:0] TicksSteps = 6'd24;
  localparam logic [DivCntW-1:0] BatchSteps = 6'd48;

  // dual serial multiplier
  localparam int unsigned MulAccW = 51;
  localparam int unsigned MulCntW = 5;
  localparam logic [MulCntW-1:0] MulSteps = 5'd17;
  localparam logic signed [MulAccW-1:0] RoundBias = 51'sd32768;

  localparam logic [QW-1:0]  QOne      = 17'd65536;
  localparam logic [15:0]    TruthMin  = 16'd58982;
  localparam logic [15:0]    TruthMax  = 16'd65470;
  localparam logic [13:0]    ValMin    = 14'd655;
  localparam logic [13:0]    ValMax    = 14'd13107;
  localparam logic [17:0]    BatchMin  = 18'd256;
  localparam logic [17:0]    BatchMax  = 18'd200000;
  localparam logic [QW-1:0]  InitAct   = 17'd39322;

  typedef enum logic [2:0] {
    RegTargetLoad    = 3'd0,
    RegThresholdGain = 3'd1,
    RegDecayGain     = 3'd2,
    RegThresholdLow  = 3'd3,
    RegThresholdHigh = 3'd4,
    RegDecayLow      = 3'd5,
    RegSweepPeriod   = 3'd6,
    RegTickPeriod    = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    DivLoad  = 2'd0,
    DivTicks = 2'd1,
    DivBatch = 2'd2
  } div_op_e;

  typedef enum logic [3:0] {
    S_IDLE       = 4'd0,
    S_LOAD_GO    = 4'd1,
    S_LOAD_WAIT  = 4'd2,
    S_LOAD_TAKE  = 4'd3,
    S_MUL_GO     = 4'd4,
    S_MUL_WAIT   = 4'd5,
    S_UPDATE     = 4'd6,
    S_TICK_WAIT  = 4'd7,
    S_BATCH_GO   = 4'd8,
    S_BATCH_WAIT = 4'd9,
    S_OUT        = 4'd10
  } lrtt_state_e;

  typedef struct packed {
    logic [QW-1:0]     load_setpoint;
    logic [QW-1:0]     threshold_gain;
    logic [QW-1:0]     decay_gain;
    logic [QW-1:0]     threshold_low;
    logic [QW-1:0]     threshold_high;
    logic [QW-1:0]     decay_low;
    logic [SweepW-1:0] sweep_period;
    logic [TickW-1:0]  tick_period;
  } lrtt_cfg_t;

  localparam lrtt_cfg_t CfgReset = '{
    load_setpoint:  17'd45875,
    threshold_gain: 17'd3277,
    decay_gain:     17'd1311,
    threshold_low:  17'd19661,
    threshold_high: 17'd62259,
    decay_low:      17'd49152,
    sweep_period:   24'd3600,
    tick_period:    16'd10
  };

  typedef struct packed {
    logic    capture;
    logic    div_start;
    div_op_e div_op;
    logic    load_take;
    logic    mul_start;
    logic    update;
    logic    out_load;
  } lrtt_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic mul_busy;
  } lrtt_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/lrtt_div.sv =====
`default_nettype none

// restoring divider, one quotient bit a cycle; dividend comes left-aligned
module lrtt_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [lrtt_pkg::DivW-1:0]         dividend_i,
  input  wire logic [lrtt_pkg::DvsW-1:0]         divisor_i,
  input  wire logic [lrtt_pkg::DivCntW-1:0]      steps_i,
  output logic                                   busy_o,
  output logic [lrtt_pkg::DivW-1:0]              quot_o
);

  logic [lrtt_pkg::DivW-1:0]    quo_q;
  logic [lrtt_pkg::DvsW-1:0]    rem_q;
  logic [lrtt_pkg::DvsW-1:0]    dvs_q;
  logic [lrtt_pkg::DivCntW-1:0] cnt_q;
  logic                         busy_q;

  logic [lrtt_pkg::DvsW:0] trial;
  logic [lrtt_pkg::DvsW:0] diff;
  logic                    ge;

  assign trial = {rem_q, quo_q[lrtt_pkg::DivW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == 1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[lrtt_pkg::DivW-2:0], ge};
      rem_q <= ge ? diff[lrtt_pkg::DvsW-1:0] : trial[lrtt_pkg::DvsW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/core/lrtt_mul.sv =====
`default_nettype none

// two shift-add multipliers sharing one signed multiplicand, lsb of gain first
module lrtt_mul (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic signed [32:0]          mcand_i,
  input  wire logic [lrtt_pkg::QW-1:0]     gain_a_i,
  input  wire logic [lrtt_pkg::QW-1:0]     gain_b_i,
  output logic                             busy_o,
  output logic signed [34:0]               step_a_o,
  output logic signed [34:0]               step_b_o
);

  logic signed [lrtt_pkg::MulAccW-1:0] mc_q;
  logic signed [lrtt_pkg::MulAccW-1:0] acc_a_q;
  logic signed [lrtt_pkg::MulAccW-1:0] acc_b_q;
  logic [lrtt_pkg::QW-1:0]             ga_q;
  logic [lrtt_pkg::QW-1:0]             gb_q;
  logic [lrtt_pkg::MulCntW-1:0]        cnt_q;
  logic                                busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= lrtt_pkg::MulSteps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == 1) begin
        busy_q <= 1'b0;
      end
    end
  end

  // accumulators start at the rounding bias so the step is a plain shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mc_q    <= {{(lrtt_pkg::MulAccW-33){mcand_i[32]}}, mcand_i};
      ga_q    <= gain_a_i;
      gb_q    <= gain_b_i;
      acc_a_q <= lrtt_pkg::RoundBias;
      acc_b_q <= lrtt_pkg::RoundBias;
    end else if (busy_q) begin
      if (ga_q[0]) begin
        acc_a_q <= acc_a_q + mc_q;
      end
      if (gb_q[0]) begin
        acc_b_q <= acc_b_q + mc_q;
      end
      mc_q <= mc_q <<< 1;
      ga_q <= ga_q >> 1;
      gb_q <= gb_q >> 1;
    end
  end

  assign busy_o   = busy_q;
  assign step_a_o = acc_a_q[lrtt_pkg::MulAccW-1:16];
  assign step_b_o = acc_b_q[lrtt_pkg::MulAccW-1:16];

endmodule

`default_nettype wire

// ===== rtl/core/lrtt_dp.sv =====
`default_nettype none

module lrtt_dp #(
  parameter int unsigned COUNT_WIDTH       = 16,
  parameter int unsigned INIT_DECAY_FACTOR = 62259
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lrtt_pkg::lrtt_cmd_t             cmd_i,
  output lrtt_pkg::lrtt_status_t               status_o,
  input  wire lrtt_pkg::lrtt_cfg_t             cfg_i,
  input  wire logic [lrtt_pkg::CountW-1:0]     occupied_i,
  input  wire logic [lrtt_pkg::CountW-1:0]     capacity_i,
  input  wire logic [lrtt_pkg::TotalW-1:0]     total_records_i,
  output logic [lrtt_pkg::QW-1:0]              activation_level_o,
  output logic [lrtt_pkg::QW-1:0]              decay_factor_o,
  output logic [15:0]                          truth_decay_o,
  output logic [13:0]                          valence_pull_o,
  output logic [17:0]                          batch_count_o
);

  localparam int unsigned MaskBits =
    (COUNT_WIDTH < lrtt_pkg::CountW) ? COUNT_WIDTH : lrtt_pkg::CountW;
  localparam logic [lrtt_pkg::CountW-1:0] CountMask =
    lrtt_pkg::CountW'((33'd1 << MaskBits) - 33'd1);
  localparam logic [lrtt_pkg::QW-1:0] InitDecay = lrtt_pkg::QW'(INIT_DECAY_FACTOR);

  logic [lrtt_pkg::CountW-1:0] occ_q;
  logic [lrtt_pkg::CountW-1:0] cap_q;
  logic [lrtt_pkg::TotalW-1:0] total_q;
  logic [31:0]                 load_q;
  logic [lrtt_pkg::QW-1:0]     act_q;
  logic [lrtt_pkg::QW-1:0]     dec_q;

  logic [lrtt_pkg::QW-1:0] act_out_q;
  logic [lrtt_pkg::QW-1:0] dec_out_q;
  logic [15:0]             truth_out_q;
  logic [13:0]             val_out_q;
  logic [17:0]             batch_out_q;

  logic [lrtt_pkg::DivW-1:0]    dividend;
  logic [lrtt_pkg::DvsW-1:0]    divisor;
  logic [lrtt_pkg::DivCntW-1:0] steps;
  logic [lrtt_pkg::DivW-1:0]    quot;
  logic                         div_busy;
  logic [lrtt_pkg::DvsW-1:0]    tps_eff;
  logic [lrtt_pkg::TickW-1:0]   tick_eff;

  logic signed [32:0] err;
  logic signed [34:0] step_a;
  logic signed [34:0] step_b;
  logic               mul_busy;
  logic signed [35:0] act_sum;
  logic signed [35:0] dec_sum;

  logic signed [17:0] sti;
  logic signed [17:0] half;
  logic signed [17:0] truth_v;
  logic [15:0]        truth_c;
  logic [13:0]        val_c;
  logic [17:0]        batch_c;

  function automatic logic [lrtt_pkg::QW-1:0] clamp_q(
    input logic signed [35:0]      v,
    input logic [lrtt_pkg::QW-1:0] lo,
    input logic [lrtt_pkg::QW-1:0] hi
  );
    logic signed [35:0]      lo_s;
    logic signed [35:0]      hi_s;
    logic [lrtt_pkg::QW-1:0] r;
    lo_s = signed'({19'd0, lo});
    hi_s = signed'({19'd0, hi});
    // crossed window: below low wins
    if (v < lo_s) begin
      r = lo;
    end else if (v > hi_s) begin
      r = hi;
    end else begin
      r = v[lrtt_pkg::QW-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      occ_q   <= occupied_i & CountMask;
      cap_q   <= capacity_i & CountMask;
      total_q <= total_records_i;
    end
    if (cmd_i.load_take) begin
      load_q <= (cap_q == '0) ? 32'd0 : quot[31:0];
    end
  end

  assign tick_eff = (cfg_i.tick_period == '0) ? 16'd1 : cfg_i.tick_period;
  assign tps_eff  = (quot[lrtt_pkg::DvsW-1:0] == '0) ? 24'd1 : quot[lrtt_pkg::DvsW-1:0];

  always_comb begin
    case (cmd_i.div_op)
      lrtt_pkg::DivTicks: begin
        dividend = {cfg_i.sweep_period, 24'd0};
        divisor  = {8'd0, tick_eff};
        steps    = lrtt_pkg::TicksSteps;
      end
      lrtt_pkg::DivBatch: begin
        dividend = total_q;
        divisor  = tps_eff;
        steps    = lrtt_pkg::BatchSteps;
      end
      default: begin
        dividend = {occ_q, 32'd0};
        divisor  = {8'd0, cap_q};
        steps    = lrtt_pkg::LoadSteps;
      end
    endcase
  end

  lrtt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .steps_i    (steps),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign err = signed'({1'b0, load_q}) - signed'({16'd0, cfg_i.load_setpoint});

  lrtt_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mul_start),
    .mcand_i  (err),
    .gain_a_i (cfg_i.threshold_gain),
    .gain_b_i (cfg_i.decay_gain),
    .busy_o   (mul_busy),
    .step_a_o (step_a),
    .step_b_o (step_b)
  );

  assign act_sum = signed'({19'd0, act_q}) + {step_a[34], step_a};
  assign dec_sum = signed'({19'd0, dec_q}) - {step_b[34], step_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= lrtt_pkg::InitAct;
      dec_q <= InitDecay;
    end else if (cmd_i.update) begin
      act_q <= clamp_q(act_sum, cfg_i.threshold_low, cfg_i.threshold_high);
      dec_q <= clamp_q(dec_sum, cfg_i.decay_low, lrtt_pkg::QOne);
    end
  end

  // h = floor((1.0 - decay) / 2), negative when the floor sits above one
  assign sti     = 18'sd65536 - signed'({1'b0, dec_q});
  assign half    = sti >>> 1;
  assign truth_v = 18'sd65536 - half;

  always_comb begin
    if (truth_v < signed'({2'b00, lrtt_pkg::TruthMin})) begin
      truth_c = lrtt_pkg::TruthMin;
    end else if (truth_v > signed'({2'b00, lrtt_pkg::TruthMax})) begin
      truth_c = lrtt_pkg::TruthMax;
    end else begin
      truth_c = truth_v[15:0];
    end
    if (half < signed'({4'd0, lrtt_pkg::ValMin})) begin
      val_c = lrtt_pkg::ValMin;
    end else if (half > signed'({4'd0, lrtt_pkg::ValMax})) begin
      val_c = lrtt_pkg::ValMax;
    end else begin
      val_c = half[13:0];
    end
    if (quot < {30'd0, lrtt_pkg::BatchMin}) begin
      batch_c = lrtt_pkg::BatchMin;
    end else if (quot > {30'd0, lrtt_pkg::BatchMax}) begin
      batch_c = lrtt_pkg::BatchMax;
    end else begin
      batch_c = quot[17:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      act_out_q   <= act_q;
      dec_out_q   <= dec_q;
      truth_out_q <= truth_c;
      val_out_q   <= val_c;
      batch_out_q <= batch_c;
    end
  end

  assign status_o.div_busy = div_busy;
  assign status_o.mul_busy = mul_busy;

  assign activation_level_o = act_out_q;
  assign decay_factor_o     = dec_out_q;
  assign truth_decay_o      = truth_out_q;
  assign valence_pull_o     = val_out_q;
  assign batch_count_o      = batch_out_q;

endmodule

`default_nettype wire

// ===== rtl/core/lrtt_ctrl.sv =====
`default_nettype none

module lrtt_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output lrtt_pkg::lrtt_cmd_t         cmd_o,
  input  wire lrtt_pkg::lrtt_status_t status_i
);

`include "load_regulated_threshold_tuner_assert.svh"

  lrtt_pkg::lrtt_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrtt_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.div_op = lrtt_pkg::DivLoad;
    unique case (state_q)
      lrtt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = lrtt_pkg::S_LOAD_GO;
        end
      end
      lrtt_pkg::S_LOAD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = lrtt_pkg::DivLoad;
        state_d         = lrtt_pkg::S_LOAD_WAIT;
      end
      lrtt_pkg::S_LOAD_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = lrtt_pkg::S_LOAD_TAKE;
        end
      end
      lrtt_pkg::S_LOAD_TAKE: begin
        // ticks-per-sweep division runs under the multiply
        cmd_o.load_take = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = lrtt_pkg::DivTicks;
        state_d         = lrtt_pkg::S_MUL_GO;
      end
      lrtt_pkg::S_MUL_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d         = lrtt_pkg::S_MUL_WAIT;
      end
      lrtt_pkg::S_MUL_WAIT: begin
        if (!status_i.mul_busy) begin
          state_d = lrtt_pkg::S_UPDATE;
        end
      end
      lrtt_pkg::S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = lrtt_pkg::S_TICK_WAIT;
      end
      lrtt_pkg::S_TICK_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = lrtt_pkg::S_BATCH_GO;
        end
      end
      lrtt_pkg::S_BATCH_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = lrtt_pkg::DivBatch;
        state_d         = lrtt_pkg::S_BATCH_WAIT;
      end
      lrtt_pkg::S_BATCH_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = lrtt_pkg::S_OUT;
        end
      end
      lrtt_pkg::S_OUT: begin
        // wait until the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = lrtt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lrtt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `LRTT_ASSERT_IMP(a_no_result_overwrite, clk_i, rst_ni,
                   cmd_o.out_load, !out_valid_q || out_ready_i)
  `LRTT_ASSERT_IMP(a_div_start_idle, clk_i, rst_ni,
                   cmd_o.div_start, !status_i.div_busy)
  `LRTT_ASSERT_IMP(a_mul_start_idle, clk_i, rst_ni,
                   cmd_o.mul_start, !status_i.mul_busy)
  `LRTT_ASSERT_NXT(a_request_starts_work, clk_i, rst_ni,
                   in_valid_i && in_ready_o,
                   state_q == lrtt_pkg::S_LOAD_GO && !in_ready_o)

endmodule

`default_nettype wire

// ===== rtl/core/load_regulated_threshold_tuner.sv =====
`default_nettype none

// channel   direction  handshake              payload
// in        sink       in_valid_i/in_ready_o  occupied, capacity, total_records
// out       source     out_valid_o/out_ready_i activation_level, decay_factor,
//                                             truth_decay, valence_pull, batch_count
// cfg       apb slave  psel/penable/pready    8 registers at 4*index, 32-bit data
//
// request to result is paced by the shared serial divider:
// 32 steps for the load, 24 for ticks per sweep (mostly under the 17-step
// multiply) and 48 for the batch size, one request at a time.
// a new request is taken the cycle after the result enters the output register,
// even while that result waits; a stalled output holds the block in its last state.
// async active-low reset restores the register defaults and both integrators.
module load_regulated_threshold_tuner #(
  parameter int unsigned COUNT_WIDTH       = 16,
  parameter int unsigned INIT_DECAY_FACTOR = 62259
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [lrtt_pkg::CountW-1:0]     occupied_i,
  input  wire logic [lrtt_pkg::CountW-1:0]     capacity_i,
  input  wire logic [lrtt_pkg::TotalW-1:0]     total_records_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [lrtt_pkg::QW-1:0]              activation_level_o,
  output logic [lrtt_pkg::QW-1:0]              decay_factor_o,
  output logic [15:0]                          truth_decay_o,
  output logic [13:0]                          valence_pull_o,
  output logic [17:0]                          batch_count_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lrtt_pkg::AddrW-1:0]      paddr,
  input  wire logic [lrtt_pkg::DataW-1:0]      pwdata,
  output logic [lrtt_pkg::DataW-1:0]           prdata,
  output logic                                 pready
);

  lrtt_pkg::lrtt_cfg_t    cfg_q, cfg_d;
  lrtt_pkg::reg_idx_e     reg_idx;
  lrtt_pkg::lrtt_cmd_t    cmd;
  lrtt_pkg::lrtt_status_t status;
  logic                   wr_en;

  assign pready  = 1'b1;
  assign reg_idx = lrtt_pkg::reg_idx_e'(paddr[lrtt_pkg::AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        lrtt_pkg::RegTargetLoad:    cfg_d.load_setpoint  = pwdata[lrtt_pkg::QW-1:0];
        lrtt_pkg::RegThresholdGain: cfg_d.threshold_gain = pwdata[lrtt_pkg::QW-1:0];
        lrtt_pkg::RegDecayGain:     cfg_d.decay_gain     = pwdata[lrtt_pkg::QW-1:0];
        lrtt_pkg::RegThresholdLow:  cfg_d.threshold_low  = pwdata[lrtt_pkg::QW-1:0];
        lrtt_pkg::RegThresholdHigh: cfg_d.threshold_high = pwdata[lrtt_pkg::QW-1:0];
        lrtt_pkg::RegDecayLow:      cfg_d.decay_low      = pwdata[lrtt_pkg::QW-1:0];
        lrtt_pkg::RegSweepPeriod:   cfg_d.sweep_period   = pwdata[lrtt_pkg::SweepW-1:0];
        lrtt_pkg::RegTickPeriod:    cfg_d.tick_period    = pwdata[lrtt_pkg::TickW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lrtt_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      lrtt_pkg::RegTargetLoad:    prdata = {15'd0, cfg_q.load_setpoint};
      lrtt_pkg::RegThresholdGain: prdata = {15'd0, cfg_q.threshold_gain};
      lrtt_pkg::RegDecayGain:     prdata = {15'd0, cfg_q.decay_gain};
      lrtt_pkg::RegThresholdLow:  prdata = {15'd0, cfg_q.threshold_low};
      lrtt_pkg::RegThresholdHigh: prdata = {15'd0, cfg_q.threshold_high};
      lrtt_pkg::RegDecayLow:      prdata = {15'd0, cfg_q.decay_low};
      lrtt_pkg::RegSweepPeriod:   prdata = {8'd0, cfg_q.sweep_period};
      lrtt_pkg::RegTickPeriod:    prdata = {16'd0, cfg_q.tick_period};
      default:                    prdata = '0;
    endcase
  end

  lrtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  lrtt_dp #(
    .COUNT_WIDTH       (COUNT_WIDTH),
    .INIT_DECAY_FACTOR (INIT_DECAY_FACTOR)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_i              (cfg_q),
    .occupied_i         (occupied_i),
    .capacity_i         (capacity_i),
    .total_records_i    (total_records_i),
    .activation_level_o (activation_level_o),
    .decay_factor_o     (decay_factor_o),
    .truth_decay_o      (truth_decay_o),
    .valence_pull_o     (valence_pull_o),
    .batch_count_o      (batch_count_o)
  );

endmodule

`default_nettype wire
